>>> rtl/core/scba_pkg.sv
// Package of the size-class block allocator: field widths, status and action
// codes, and default parameter values. Depends on nothing.
`default_nettype none
package scba_pkg;

    localparam int ACTION_W = 1;
    localparam int SIZE_W   = 16;
    localparam int HANDLE_W = 6;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_BUCKETS           = 4;
    localparam int DEFAULT_BLOCKS_PER_BUCKET = 16;
    localparam int DEFAULT_UNIT_BYTES        = 8;

    localparam logic [ACTION_W-1:0] ACTION_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/scba_if.sv
// Handshake interfaces of the allocator: the request and the response channel.
// Depends on scba_pkg for the field widths.
`default_nettype none
interface scba_req_if;
    logic                           valid;
    logic                           ready;
    logic [scba_pkg::ACTION_W-1:0]  action;
    logic [scba_pkg::SIZE_W-1:0]    request_size;
    logic [scba_pkg::HANDLE_W-1:0]  free_handle;

    modport source (output valid, output action, output request_size,
                    output free_handle, input ready);
    modport sink   (input valid, input action, input request_size,
                    input free_handle, output ready);
endinterface

interface scba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [scba_pkg::HANDLE_W-1:0]  granted_handle;
    logic [scba_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output granted_handle, output status, input ready);
    modport sink   (input valid, input granted_handle, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/scba_slot_mem.sv
// Synchronous slot memory holding every bucket's free stack, one write and one
// registered read port. Depends on nothing.
`default_nettype none
module scba_slot_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/size_class_block_allocator_core.sv
// Top level of the size-class block allocator: request decode, stack depth
// registers and control. Depends on scba_pkg, scba_if and scba_slot_mem.
//
// Requests arrive as items on req and each gives exactly one item on rsp.
// An allocate item picks the smallest bucket whose size limit covers the
// requested bytes and pops a slot from that bucket's stack; a free item pushes
// the handle's slot back onto its bucket. Errors are reported in status.
// A free item or an error is written straight into the response register on
// acceptance; a successful allocate first passes through ST_READ, as the popped
// slot comes from the registered read port of the synchronous slot memory. The
// block holds one request at a time and takes no new one while in ST_READ.
// After reset a clearing pass over every slot address writes
// every stack full; req.ready stays low until it ends. The response sits in an
// output register; while the receiver stalls, that item waits there and a new
// request is taken only in the cycle in which it is taken or once it is gone.
`default_nettype none
module size_class_block_allocator_core #(
    parameter int BUCKETS           = scba_pkg::DEFAULT_BUCKETS,
    parameter int BLOCKS_PER_BUCKET = scba_pkg::DEFAULT_BLOCKS_PER_BUCKET,
    parameter int UNIT_BYTES        = scba_pkg::DEFAULT_UNIT_BYTES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    scba_req_if.sink    req,
    scba_rsp_if.source  rsp
);

    localparam int DEPTH  = BUCKETS * BLOCKS_PER_BUCKET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(BLOCKS_PER_BUCKET);
    localparam int CNT_W  = $clog2(BLOCKS_PER_BUCKET + 1);
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int HW     = scba_pkg::HANDLE_W;

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_IDLE = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      init_addr_reg, init_addr_next;
    logic [SLOT_W-1:0]      init_slot_reg, init_slot_next;
    logic [CNT_W-1:0]       cnt_reg [BUCKETS];
    logic [CNT_W-1:0]       cnt_next [BUCKETS];
    logic [BKT_W-1:0]       bkt_reg, bkt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HW-1:0]          handle_reg, handle_next;
    scba_pkg::status_t      status_reg, status_next;

    logic                   fit_found;
    logic [BKT_W-1:0]       fit_bkt;
    logic                   free_in_range;
    logic [BKT_W-1:0]       free_bkt;
    logic [HW-1:0]          free_base;
    logic [SLOT_W-1:0]      free_slot;
    logic [CNT_W-1:0]       alloc_cnt;
    logic [CNT_W-1:0]       free_cnt;
    logic                   accept;

    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_wr_addr;
    logic [SLOT_W-1:0]      mem_wr_data;
    logic                   mem_rd_en;
    logic [ADDR_W-1:0]      mem_rd_addr;
    logic [SLOT_W-1:0]      mem_rd_data;

    scba_slot_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Smallest fitting bucket wins, hence the descending scan.
    always_comb
    begin
        fit_found = 1'b0;
        fit_bkt   = '0;
        for (int i = BUCKETS - 1; i >= 0; i--)
        begin
            if (32'(req.request_size) <= (32'(UNIT_BYTES) << i))
            begin
                fit_found = 1'b1;
                fit_bkt   = BKT_W'(i);
            end
        end
    end

    always_comb
    begin
        free_in_range = 32'(req.free_handle) < 32'(DEPTH);
        free_bkt      = '0;
        free_base     = '0;
        for (int i = 1; i < BUCKETS; i++)
        begin
            if (32'(req.free_handle) >= 32'(i * BLOCKS_PER_BUCKET))
            begin
                free_bkt  = BKT_W'(i);
                free_base = HW'(i * BLOCKS_PER_BUCKET);
            end
        end
        free_slot = SLOT_W'(req.free_handle - free_base);
    end

    assign alloc_cnt = cnt_reg[fit_bkt];
    assign free_cnt  = cnt_reg[free_bkt];
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        init_slot_next = init_slot_reg;
        cnt_next       = cnt_reg;
        bkt_next       = bkt_reg;
        out_valid_next = out_valid_reg;
        handle_next    = handle_reg;
        status_next    = status_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = ADDR_W'(free_bkt) * ADDR_W'(BLOCKS_PER_BUCKET) + ADDR_W'(free_cnt);
        mem_wr_data    = free_slot;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = ADDR_W'(fit_bkt) * ADDR_W'(BLOCKS_PER_BUCKET)
                         + ADDR_W'(alloc_cnt - CNT_W'(1));

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                mem_wr_en      = 1'b1;
                mem_wr_addr    = init_addr_reg;
                mem_wr_data    = init_slot_reg;
                init_addr_next = init_addr_reg + ADDR_W'(1);
                init_slot_next = (init_slot_reg == SLOT_W'(BLOCKS_PER_BUCKET - 1))
                                 ? '0 : init_slot_reg + SLOT_W'(1);
                if (init_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    handle_next = '0;
                    if (req.action == scba_pkg::ACTION_ALLOC)
                    begin
                        if (!fit_found)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = scba_pkg::STATUS_TOO_LARGE;
                        end
                        else if (alloc_cnt == '0)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = scba_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en         = 1'b1;
                            cnt_next[fit_bkt] = alloc_cnt - CNT_W'(1);
                            bkt_next          = fit_bkt;
                            state_next        = ST_READ;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (!free_in_range || free_cnt >= CNT_W'(BLOCKS_PER_BUCKET))
                        begin
                            status_next = scba_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            mem_wr_en          = 1'b1;
                            cnt_next[free_bkt] = free_cnt + CNT_W'(1);
                            status_next        = scba_pkg::STATUS_OK;
                        end
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                handle_next    = HW'(32'(bkt_reg) * BLOCKS_PER_BUCKET + 32'(mem_rd_data));
                status_next    = scba_pkg::STATUS_OK;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            init_slot_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                cnt_reg[i] <= CNT_W'(BLOCKS_PER_BUCKET);
            end
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            init_slot_reg <= init_slot_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bkt_reg    <= bkt_next;
        handle_reg <= handle_next;
        status_reg <= status_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.granted_handle = handle_reg;
    assign rsp.status         = status_reg;

    // The output register must be free when the popped slot returns.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !out_valid_reg)
        else $error("Response register busy when read data returned.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !req.ready)
        else $error("Request taken during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == scba_pkg::ACTION_ALLOC && fit_found && alloc_cnt != '0)
        |=> (state_reg == ST_READ && cnt_reg[bkt_reg] == $past(alloc_cnt) - CNT_W'(1)))
        else $error("Successful allocate did not pop its bucket.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == ST_READ) |-> (out_valid_reg && status_reg == scba_pkg::STATUS_OK))
        else $error("Allocate response missing after slot read.");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the size-class block allocator: directed and random
// allocate and free items, predicted per bucket stack and checked per response.
// Depends on scba_pkg, scba_if and size_class_block_allocator_core.
module tb_top;
    import scba_pkg::*;

    localparam int NUM_BUCKETS   = DEFAULT_BUCKETS;
    localparam int SLOTS         = DEFAULT_BLOCKS_PER_BUCKET;
    localparam int UNIT          = DEFAULT_UNIT_BYTES;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int CALM_FROM     = 3000;
    localparam int CALM_TO       = 4500;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
        logic                wait_drain;
    } request_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        status_t             status;
    } grant_t;

    logic clk;
    logic rst_n;

    scba_req_if req_ch ();
    scba_rsp_if rsp_ch ();

    size_class_block_allocator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    request_t pending_requests[$];
    grant_t   expected_grants[$];
    request_t held_request;

    logic [HANDLE_W-1:0] slot_stack[NUM_BUCKETS][SLOTS];
    int                  stack_depth[NUM_BUCKETS];

    int issued_count;
    int granted_count;
    int total_requests;
    int error_count;
    int cycle_count;
    logic calm;

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        error_count++;
    endtask

    function automatic void predict_grant(input request_t r);
        grant_t g;
        int     b;
        int     bk;
        logic   found;
        g.handle = '0;
        g.status = STATUS_TOO_LARGE;
        found = 1'b0;
        if (r.act == ACTION_ALLOC)
        begin
            for (b = 0; b < NUM_BUCKETS; b++)
            begin
                if (!found && (int'(r.size) <= (UNIT << b)))
                begin
                    found = 1'b1;
                    if (stack_depth[b] == 0)
                    begin
                        g.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        stack_depth[b]--;
                        g.handle = HANDLE_W'(b * SLOTS) + slot_stack[b][stack_depth[b]];
                        g.status = STATUS_OK;
                    end
                end
            end
        end
        else
        begin
            bk = int'(r.handle) / SLOTS;
            if (bk >= NUM_BUCKETS || stack_depth[bk] >= SLOTS)
            begin
                g.status = STATUS_OVERFLOW;
            end
            else
            begin
                slot_stack[bk][stack_depth[bk]] = HANDLE_W'(int'(r.handle) % SLOTS);
                stack_depth[bk]++;
                g.status = STATUS_OK;
            end
        end
        expected_grants.push_back(g);
    endfunction

    function automatic request_t alloc_request(input int size, input int handle);
        request_t r;
        r.act = ACTION_ALLOC;
        r.size = SIZE_W'(size);
        r.handle = HANDLE_W'(handle);
        r.wait_drain = 1'b0;
        return r;
    endfunction

    function automatic request_t free_request(input int handle, input int size);
        request_t r;
        r.act = ACTION_FREE;
        r.size = SIZE_W'(size);
        r.handle = HANDLE_W'(handle);
        r.wait_drain = 1'b0;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == CYCLE_LIMIT)
            begin
                $display("size_class_block_allocator_core: mismatch");
                $finish;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.action <= ACTION_ALLOC;
            req_ch.request_size <= '0;
            req_ch.free_handle <= '0;
            issued_count = 0;
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                for (int j = 0; j < SLOTS; j++)
                begin
                    slot_stack[b][j] = HANDLE_W'(j);
                end
                stack_depth[b] = SLOTS;
            end
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_grant(held_request);
                issued_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() > 0
                    && (calm || $urandom_range(0, 99) >= 25)
                    && (!pending_requests[0].wait_drain || issued_count == granted_count))
                begin
                    held_request = pending_requests.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.action <= held_request.act;
                    req_ch.request_size <= held_request.size;
                    req_ch.free_handle <= held_request.handle;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            granted_count <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                granted_count <= granted_count + 1;
                if (expected_grants.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected response: handle %0d status %0d",
                                              rsp_ch.granted_handle, rsp_ch.status));
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp_ch.granted_handle !== want.handle)
                    begin
                        report_mismatch($sformatf("response %0d: handle %0d, expected %0d",
                                                  granted_count, rsp_ch.granted_handle,
                                                  want.handle));
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        report_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                                  granted_count, rsp_ch.status, want.status));
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        request_t r;
        int       focus;
        int       alloc_pct;
        int       burst;
        int       lo;
        int       hi;
        int       pick;
        int       made;

        error_count = 0;
        made = 0;

        pending_requests.push_back(alloc_request(0, 0));
        pending_requests.push_back(alloc_request(UNIT, 63));
        pending_requests.push_back(alloc_request(UNIT + 1, 21));
        pending_requests.push_back(alloc_request(UNIT * 2, 42));
        pending_requests.push_back(alloc_request(UNIT * 2 + 1, 0));
        pending_requests.push_back(alloc_request(UNIT * 4, 63));
        pending_requests.push_back(alloc_request(UNIT * 4 + 1, 0));
        pending_requests.push_back(alloc_request(UNIT * 8, 63));
        pending_requests.push_back(alloc_request(UNIT * 8 + 1, 0));
        pending_requests.push_back(alloc_request(65535, 63));
        pending_requests.push_back(free_request(15, 65535));
        pending_requests.push_back(free_request(0, 0));
        pending_requests.push_back(free_request(3, 21845));
        pending_requests.push_back(free_request(31, 43690));
        pending_requests.push_back(free_request(47, 0));
        pending_requests.push_back(free_request(63, 65535));
        pending_requests.push_back(free_request(48, 0));
        pending_requests.push_back(free_request(62, 0));
        pending_requests.push_back(alloc_request(1, 0));

        while (made < RANDOM_ITEMS)
        begin
            focus = $urandom_range(0, NUM_BUCKETS - 1);
            pick = $urandom_range(0, 2);
            alloc_pct = (pick == 0) ? 10 : ((pick == 1) ? 50 : 90);
            burst = $urandom_range(8, 48);
            lo = (focus == 0) ? 0 : (UNIT << (focus - 1)) + 1;
            hi = UNIT << focus;
            for (int j = 0; j < burst; j++)
            begin
                if ($urandom_range(0, 99) < alloc_pct)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                    begin
                        r = alloc_request($urandom_range(lo, hi), $urandom_range(0, 63));
                    end
                    else if (pick < 93)
                    begin
                        r = alloc_request(hi, $urandom_range(0, 63));
                    end
                    else
                    begin
                        r = alloc_request($urandom_range((UNIT << (NUM_BUCKETS - 1)) + 1, 65535),
                                          $urandom_range(0, 63));
                    end
                end
                else
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        r = free_request(focus * SLOTS + $urandom_range(0, SLOTS - 1),
                                         $urandom_range(0, 65535));
                    end
                    else
                    begin
                        r = free_request($urandom_range(0, 63), $urandom_range(0, 65535));
                    end
                end
                made++;
                r.wait_drain = (made % 300 == 0);
                pending_requests.push_back(r);
            end
        end
        total_requests = pending_requests.size();

        @(negedge clk);
        while (issued_count != total_requests || granted_count != issued_count)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_grants.size() == 0)
        begin
            $display("size_class_block_allocator_core: match");
        end
        else
        begin
            $display("size_class_block_allocator_core: mismatch");
        end
        $finish;
    end

endmodule
